// ----- rtl/core/salru_pkg.sv -----
// Shared types, widths and codes for the set-associative LRU cache lookup.
`timescale 1ns / 1ps

package salru_pkg;

    // Field widths
    localparam int ADDR_W      = 32;
    localparam int BLK_W       = 30;
    localparam int TAG_W       = 30;
    localparam int SET_OUT_W   = 10;
    localparam int WAY_OUT_W   = 4;
    localparam int CNT_W       = 32;

    // Configuration registers
    localparam int CFG_KB_W    = 11;
    localparam int CFG_BW_W    = 9;
    localparam int CFG_WAYS_W  = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_KBYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS         = 2'd2;

    localparam logic [CFG_KB_W-1:0]   KBYTES_RST = 11'd4;
    localparam logic [CFG_BW_W-1:0]   BWORDS_RST = 9'd1;
    localparam logic [CFG_WAYS_W-1:0] WAYS_RST   = 5'd1;

    // Associativity limit
    localparam logic [CFG_WAYS_W-1:0] MAX_WAYS = 5'd16;

    // Line count: (kbytes * 1024) / (words * 4) stays below 2^19
    localparam int LCNT_W = CFG_KB_W + 10 - 2;
    // Bytes per block: words * 4
    localparam int BPB_W  = CFG_BW_W + 2;

    // Default depth of the line store
    localparam int DEF_MAX_LINES = 1024;

    // Shared divider
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

    // One entry of the line store
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] stamp;
    } line_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GEO,
        ST_LC,
        ST_SC,
        ST_SCHK,
        ST_BLK,
        ST_SET,
        ST_BASE,
        ST_WALK,
        ST_UPD,
        ST_OUT,
        ST_ERR
    } state_t;

endpackage

// ----- rtl/core/salru_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module salru_div
    import salru_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     dsr_reg, dsr_next;

    logic [DIV_W:0] shifted;
    logic [DIV_W:0] diff;
    logic           ge;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = (shifted >= {1'b0, dsr_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (!busy_reg && !done_reg && req.start) begin
            // load operands
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- rtl/core/salru_store.sv -----
// Line store: one write port, one registered read port.
`timescale 1ns / 1ps

module salru_store
    import salru_pkg::*;
#(
    parameter int MAX_LINES = DEF_MAX_LINES,
    localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output line_t            rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  line_t            wr_data
);

    line_t mem [MAX_LINES];
    line_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/set_assoc_cache_lru_lookup.sv -----
// Top level: set-associative cache lookup with LRU replacement.
// Each address request is split into a block number, a set and a tag using the
// geometry held in three configuration registers, the ways of that set are
// searched, and one result comes back with hit flag, chosen way and running
// access and hit totals. A hit restamps the line; a miss fills the lowest empty
// way or evicts the way with the oldest stamp. After reset the block runs a
// clearing pass over every line of the line store and takes no request until
// it ends. Configuration writes are taken only while the block is idle between
// requests, and a pending write goes ahead of a waiting request. A request
// runs two divisions in the shared divider (block number, then set and tag)
// plus one store read per way. The first request after reset or after any
// configuration write also derives the line and set counts, which adds two
// more divisions. A configuration error is answered without a division once
// the geometry is known. A finished result waits in an output register, so the
// next request can be taken and processed while it is not yet collected.
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup
    import salru_pkg::*;
#(
    parameter int MAX_LINES = DEF_MAX_LINES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ADDR_W-1:0]     s_address,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [BLK_W-1:0]      m_block_number,
    output logic [SET_OUT_W-1:0]  m_set_index,
    output logic [TAG_W-1:0]      m_line_tag,
    output logic [WAY_OUT_W-1:0]  m_way_used,
    output logic [CNT_W-1:0]      m_access_number,
    output logic [CNT_W-1:0]      m_hit_total,
    output logic                  m_config_error
);

    localparam int IDX_W      = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int PROD_W     = IDX_W + CFG_WAYS_W;
    localparam int GEO_PROD_W = LCNT_W + CFG_WAYS_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;

    logic [CFG_KB_W-1:0]   kbytes_reg, kbytes_next;
    logic [CFG_BW_W-1:0]   bwords_reg, bwords_next;
    logic [CFG_WAYS_W-1:0] ways_reg, ways_next;

    // cached geometry, dropped on any configuration write
    logic                  geo_ok_reg, geo_ok_next;
    logic                  geo_err_reg, geo_err_next;
    logic [LCNT_W-1:0]     line_cnt_reg, line_cnt_next;
    logic [LCNT_W-1:0]     set_cnt_reg, set_cnt_next;

    // per-request datapath
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [BLK_W-1:0]      blk_reg, blk_next;
    logic [IDX_W-1:0]      set_reg, set_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;
    logic [IDX_W-1:0]      base_reg, base_next;

    // way walk
    logic [CFG_WAYS_W-1:0] issue_reg, issue_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [CFG_WAYS_W-1:0] rd_way_reg, rd_way_next;
    logic                  hit_found_reg, hit_found_next;
    logic [CFG_WAYS_W-1:0] hit_way_reg, hit_way_next;
    logic                  empty_found_reg, empty_found_next;
    logic [CFG_WAYS_W-1:0] empty_way_reg, empty_way_next;
    logic                  min_set_reg, min_set_next;
    logic [CNT_W-1:0]      min_stamp_reg, min_stamp_next;
    logic [CFG_WAYS_W-1:0] victim_reg, victim_next;
    logic [CFG_WAYS_W-1:0] way_reg, way_next;
    logic                  hit_reg, hit_next;

    logic [CNT_W-1:0]      acc_cnt_reg, acc_cnt_next;
    logic [CNT_W-1:0]      hit_cnt_reg, hit_cnt_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    logic                  m_hit_reg, m_hit_next;
    logic [BLK_W-1:0]      m_blk_reg, m_blk_next;
    logic [SET_OUT_W-1:0]  m_set_reg, m_set_next;
    logic [TAG_W-1:0]      m_tag_reg, m_tag_next;
    logic [WAY_OUT_W-1:0]  m_way_reg, m_way_next;
    logic [CNT_W-1:0]      m_acc_reg, m_acc_next;
    logic [CNT_W-1:0]      m_hits_reg, m_hits_next;
    logic                  m_err_reg, m_err_next;

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic             st_rd_en;
    logic [IDX_W-1:0] st_rd_idx;
    line_t            st_rd_data;
    logic             st_wr_en;
    logic [IDX_W-1:0] st_wr_idx;
    line_t            st_wr_data;

    salru_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    salru_store #(
        .MAX_LINES (MAX_LINES)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (st_rd_en),
        .rd_idx  (st_rd_idx),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_idx  (st_wr_idx),
        .wr_data (st_wr_data)
    );

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    logic                  s_acc;
    logic                  cfg_wr;
    logic                  out_free;
    logic                  basic_err;
    logic [BPB_W-1:0]      bpb;
    logic [GEO_PROD_W-1:0] geo_prod;
    logic [PROD_W-1:0]     base_prod;
    logic [CFG_WAYS_W-1:0] way_sel;
    logic                  walk_last;

    assign s_acc     = s_valid && s_ready;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign bpb       = {bwords_reg, 2'b00};
    assign basic_err = (kbytes_reg == '0) || (bwords_reg == '0) || (ways_reg == '0) ||
                       (ways_reg > MAX_WAYS);
    assign geo_prod  = GEO_PROD_W'(set_cnt_reg) * GEO_PROD_W'(ways_reg);
    assign base_prod = PROD_W'(set_reg) * PROD_W'(ways_reg);
    // hit beats empty way, empty way beats oldest stamp
    assign way_sel   = hit_found_reg   ? hit_way_reg   :
                       empty_found_reg ? empty_way_reg : victim_reg;
    // last read of the walk comes back this cycle
    assign walk_last = rd_pend_reg && (rd_way_reg == ways_reg - CFG_WAYS_W'(1));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == IDX_W'(MAX_LINES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (!geo_ok_reg) begin
                        state_next = ST_GEO;
                    end else if (geo_err_reg) begin
                        state_next = ST_ERR;
                    end else begin
                        state_next = ST_BLK;
                    end
                end
            end
            ST_GEO: begin
                state_next = basic_err ? ST_ERR : ST_LC;
            end
            ST_LC: begin
                if (div_rsp.done) begin
                    state_next = ST_SC;
                end
            end
            ST_SC: begin
                if (div_rsp.done) begin
                    state_next = ST_SCHK;
                end
            end
            ST_SCHK: begin
                if ((set_cnt_reg == '0) || (geo_prod > GEO_PROD_W'(MAX_LINES))) begin
                    state_next = ST_ERR;
                end else begin
                    state_next = ST_BLK;
                end
            end
            ST_BLK: begin
                if (div_rsp.done) begin
                    state_next = ST_SET;
                end
            end
            ST_SET: begin
                if (div_rsp.done) begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (walk_last) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                state_next = ST_OUT;
            end
            ST_OUT, ST_ERR: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: handshake, divider and store control
    // ------------------------------------------------------------------
    always_comb begin
        s_ready          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        st_rd_en         = 1'b0;
        st_rd_idx        = base_reg + IDX_W'(issue_reg);
        st_wr_en         = 1'b0;
        st_wr_idx        = clr_cnt_reg;
        st_wr_data       = '0;
        case (state_reg)
            ST_CLEAR: begin
                // sweep zeros over the whole store
                st_wr_en = 1'b1;
            end
            ST_IDLE: begin
                // hold requests while a configuration write is offered
                s_ready = !cfg_valid;
            end
            ST_LC: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({kbytes_reg, 10'b0});
                div_req.divisor  = DIV_W'(bpb);
            end
            ST_SC: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(line_cnt_reg);
                div_req.divisor  = DIV_W'(ways_reg);
            end
            ST_BLK: begin
                div_req.start    = 1'b1;
                div_req.dividend = addr_reg;
                div_req.divisor  = DIV_W'(bpb);
            end
            ST_SET: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(blk_reg);
                div_req.divisor  = DIV_W'(set_cnt_reg);
            end
            ST_WALK: begin
                st_rd_en = (issue_reg < ways_reg);
            end
            ST_UPD: begin
                // fill, replace or restamp the chosen line
                st_wr_en         = 1'b1;
                st_wr_idx        = base_reg + IDX_W'(way_sel);
                st_wr_data.valid = 1'b1;
                st_wr_data.tag   = tag_reg;
                st_wr_data.stamp = acc_cnt_reg;
            end
            default: begin
            end
        endcase
    end

    assign cfg_ready = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        clr_cnt_next     = clr_cnt_reg;
        kbytes_next      = kbytes_reg;
        bwords_next      = bwords_reg;
        ways_next        = ways_reg;
        geo_ok_next      = geo_ok_reg;
        geo_err_next     = geo_err_reg;
        line_cnt_next    = line_cnt_reg;
        set_cnt_next     = set_cnt_reg;
        addr_next        = addr_reg;
        blk_next         = blk_reg;
        set_next         = set_reg;
        tag_next         = tag_reg;
        base_next        = base_reg;
        issue_next       = issue_reg;
        rd_pend_next     = 1'b0;
        rd_way_next      = rd_way_reg;
        hit_found_next   = hit_found_reg;
        hit_way_next     = hit_way_reg;
        empty_found_next = empty_found_reg;
        empty_way_next   = empty_way_reg;
        min_set_next     = min_set_reg;
        min_stamp_next   = min_stamp_reg;
        victim_next      = victim_reg;
        way_next         = way_reg;
        hit_next         = hit_reg;
        acc_cnt_next     = acc_cnt_reg;
        hit_cnt_next     = hit_cnt_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_hit_next       = m_hit_reg;
        m_blk_next       = m_blk_reg;
        m_set_next       = m_set_reg;
        m_tag_next       = m_tag_reg;
        m_way_next       = m_way_reg;
        m_acc_next       = m_acc_reg;
        m_hits_next      = m_hits_reg;
        m_err_next       = m_err_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
            end
            ST_IDLE: begin
                if (s_acc) begin
                    addr_next = s_address;
                end
            end
            ST_GEO: begin
                if (basic_err) begin
                    geo_ok_next  = 1'b1;
                    geo_err_next = 1'b1;
                end
            end
            ST_LC: begin
                if (div_rsp.done) begin
                    line_cnt_next = LCNT_W'(div_rsp.quotient);
                end
            end
            ST_SC: begin
                if (div_rsp.done) begin
                    set_cnt_next = LCNT_W'(div_rsp.quotient);
                end
            end
            ST_SCHK: begin
                geo_ok_next  = 1'b1;
                geo_err_next = (set_cnt_reg == '0) ||
                               (geo_prod > GEO_PROD_W'(MAX_LINES));
            end
            ST_BLK: begin
                if (div_rsp.done) begin
                    blk_next = BLK_W'(div_rsp.quotient);
                end
            end
            ST_SET: begin
                if (div_rsp.done) begin
                    set_next = IDX_W'(div_rsp.remainder);
                    tag_next = TAG_W'(div_rsp.quotient);
                end
            end
            ST_BASE: begin
                // line (set, way) sits at set * ways + way
                base_next        = IDX_W'(base_prod);
                issue_next       = '0;
                hit_found_next   = 1'b0;
                empty_found_next = 1'b0;
                min_set_next     = 1'b0;
            end
            ST_WALK: begin
                if (issue_reg < ways_reg) begin
                    issue_next   = issue_reg + CFG_WAYS_W'(1);
                    rd_pend_next = 1'b1;
                    rd_way_next  = issue_reg;
                end
                if (rd_pend_reg) begin
                    if (st_rd_data.valid && (st_rd_data.tag == tag_reg) && !hit_found_reg) begin
                        hit_found_next = 1'b1;
                        hit_way_next   = rd_way_reg;
                    end
                    if (!st_rd_data.valid && !empty_found_reg) begin
                        empty_found_next = 1'b1;
                        empty_way_next   = rd_way_reg;
                    end
                    // ascending walk: ties go to the higher way
                    if (st_rd_data.valid &&
                        (!min_set_reg || (st_rd_data.stamp <= min_stamp_reg))) begin
                        min_set_next   = 1'b1;
                        min_stamp_next = st_rd_data.stamp;
                        victim_next    = rd_way_reg;
                    end
                end
            end
            ST_UPD: begin
                way_next     = way_sel;
                hit_next     = hit_found_reg;
                acc_cnt_next = acc_cnt_reg + CNT_W'(1);
                hit_cnt_next = hit_cnt_reg + CNT_W'(hit_found_reg);
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = hit_reg;
                    m_blk_next   = blk_reg;
                    m_set_next   = SET_OUT_W'(set_reg);
                    m_tag_next   = tag_reg;
                    m_way_next   = WAY_OUT_W'(way_reg);
                    m_acc_next   = acc_cnt_reg;
                    m_hits_next  = hit_cnt_reg;
                    m_err_next   = 1'b0;
                end
            end
            ST_ERR: begin
                // unusable geometry: flag only, nothing updated
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = 1'b0;
                    m_blk_next   = '0;
                    m_set_next   = '0;
                    m_tag_next   = '0;
                    m_way_next   = '0;
                    m_acc_next   = '0;
                    m_hits_next  = '0;
                    m_err_next   = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // configuration writes land only while idle; drop the cached geometry
        if (cfg_wr) begin
            geo_ok_next = 1'b0;
            case (cfg_index)
                CFG_CACHE_KBYTES: kbytes_next = cfg_data[CFG_KB_W-1:0];
                CFG_BLOCK_WORDS:  bwords_next = cfg_data[CFG_BW_W-1:0];
                CFG_WAYS:         ways_next   = cfg_data[CFG_WAYS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            kbytes_reg  <= KBYTES_RST;
            bwords_reg  <= BWORDS_RST;
            ways_reg    <= WAYS_RST;
            geo_ok_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            acc_cnt_reg <= '0;
            hit_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            kbytes_reg  <= kbytes_next;
            bwords_reg  <= bwords_next;
            ways_reg    <= ways_next;
            geo_ok_reg  <= geo_ok_next;
            rd_pend_reg <= rd_pend_next;
            acc_cnt_reg <= acc_cnt_next;
            hit_cnt_reg <= hit_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        geo_err_reg     <= geo_err_next;
        line_cnt_reg    <= line_cnt_next;
        set_cnt_reg     <= set_cnt_next;
        addr_reg        <= addr_next;
        blk_reg         <= blk_next;
        set_reg         <= set_next;
        tag_reg         <= tag_next;
        base_reg        <= base_next;
        issue_reg       <= issue_next;
        rd_way_reg      <= rd_way_next;
        hit_found_reg   <= hit_found_next;
        hit_way_reg     <= hit_way_next;
        empty_found_reg <= empty_found_next;
        empty_way_reg   <= empty_way_next;
        min_set_reg     <= min_set_next;
        min_stamp_reg   <= min_stamp_next;
        victim_reg      <= victim_next;
        way_reg         <= way_next;
        hit_reg         <= hit_next;
        m_hit_reg       <= m_hit_next;
        m_blk_reg       <= m_blk_next;
        m_set_reg       <= m_set_next;
        m_tag_reg       <= m_tag_next;
        m_way_reg       <= m_way_next;
        m_acc_reg       <= m_acc_next;
        m_hits_reg      <= m_hits_next;
        m_err_reg       <= m_err_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_block_number  = m_blk_reg;
    assign m_set_index     = m_set_reg;
    assign m_line_tag      = m_tag_reg;
    assign m_way_used      = m_way_reg;
    assign m_access_number = m_acc_reg;
    assign m_hit_total     = m_hits_reg;
    assign m_config_error  = m_err_reg;

endmodule

// ----- rtl/core/salru_chk.sv -----
// Port-level checker for the cache lookup, bound to the top level.
`timescale 1ns / 1ps

module salru_chk
    import salru_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_hit,
    input logic [BLK_W-1:0]      m_block_number,
    input logic [SET_OUT_W-1:0]  m_set_index,
    input logic [TAG_W-1:0]      m_line_tag,
    input logic [WAY_OUT_W-1:0]  m_way_used,
    input logic [CNT_W-1:0]      m_access_number,
    input logic [CNT_W-1:0]      m_hit_total,
    input logic                  m_config_error
);

    // one request in flight: take no second request right after one
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while previous one in flight");

    // an error result carries nothing but the flag
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_config_error) |->
            (!m_hit && (m_block_number == '0) && (m_line_tag == '0) &&
             (m_way_used == '0) && (m_access_number == '0) && (m_hit_total == '0)))
        else $error("error result carries data");

    // set and tag both come from the block number and never exceed it
    a_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_config_error) |->
            ((BLK_W'(m_set_index) <= m_block_number) && (m_line_tag <= m_block_number)))
        else $error("set or tag larger than block number");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_block_number) && $stable(m_access_number) &&
             $stable(m_hit_total) && $stable(m_way_used)))
        else $error("stalled result changed");

endmodule

bind set_assoc_cache_lru_lookup salru_chk u_salru_chk (.*);

// ----- bench/tb_top.sv -----
// Self-checking bench for the set-associative LRU cache lookup block.
`timescale 1ns / 1ps

module tb_top;
    import salru_pkg::*;

    // Index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int LINE_DEPTH = DEF_MAX_LINES;

    // One lookup result, laid out field by field as the result channel carries it
    typedef struct packed {
        logic                 hit;
        logic [BLK_W-1:0]     block_number;
        logic [SET_OUT_W-1:0] set_index;
        logic [TAG_W-1:0]     line_tag;
        logic [WAY_OUT_W-1:0] way_used;
        logic [CNT_W-1:0]     access_number;
        logic [CNT_W-1:0]     hit_total;
        logic                 config_error;
    } lookup_t;

    // Cache model plus the queue of lookups still owed by the block
    class cache_scoreboard;
        int unsigned           mismatches;
        logic [CFG_KB_W-1:0]   kbytes;
        logic [CFG_BW_W-1:0]   bwords;
        logic [CFG_WAYS_W-1:0] nways;
        bit                    valid_mark [LINE_DEPTH];
        logic [TAG_W-1:0]      tag_mem    [LINE_DEPTH];
        logic [CNT_W-1:0]      stamp_mem  [LINE_DEPTH];
        logic [CNT_W-1:0]      access_count;
        logic [CNT_W-1:0]      hit_count;
        lookup_t               owed_lookups [$];

        function new();
            mismatches   = 0;
            kbytes       = KBYTES_RST;
            bwords       = BWORDS_RST;
            nways        = WAYS_RST;
            access_count = '0;
            hit_count    = '0;
            foreach (valid_mark[i]) begin
                valid_mark[i] = 1'b0;
                tag_mem[i]    = '0;
                stamp_mem[i]  = '0;
            end
        endfunction

        // Geometry check: bytes per block and set count, or 0 when unusable
        static function bit geometry(input logic [CFG_KB_W-1:0] kb,
                                     input logic [CFG_BW_W-1:0] bw,
                                     input logic [CFG_WAYS_W-1:0] w,
                                     output longint unsigned bpb,
                                     output longint unsigned sc);
            longint unsigned lc;
            bpb = 0;
            sc  = 0;
            if (kb == 0 || bw == 0 || w == 0 || w > MAX_WAYS)
                return 1'b0;
            bpb = longint'(bw) * 4;
            lc  = (longint'(kb) * 1024) / bpb;
            sc  = lc / longint'(w);
            if (sc == 0 || sc * longint'(w) > LINE_DEPTH)
                return 1'b0;
            return 1'b1;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CACHE_KBYTES: kbytes = data[CFG_KB_W-1:0];
                CFG_BLOCK_WORDS:  bwords = data[CFG_BW_W-1:0];
                CFG_WAYS:         nways  = data[CFG_WAYS_W-1:0];
                default: ;
            endcase
        endfunction

        // Run one address through the cache model and queue the lookup it owes
        function void note_request(input logic [ADDR_W-1:0] addr);
            longint unsigned bpb, sc, blk, set_no, tag, base;
            int              way, victim, e;
            bit              hit, empty;
            lookup_t         want;
            want = '0;
            if (!geometry(kbytes, bwords, nways, bpb, sc)) begin
                want.config_error = 1'b1;
                owed_lookups.push_back(want);
                return;
            end
            blk    = longint'(addr) / bpb;
            set_no = blk % sc;
            tag    = blk / sc;
            base   = set_no * longint'(nways);
            hit    = 1'b0;
            empty  = 1'b0;
            way    = 0;
            for (int w = 0; w < int'(nways); w++)
                if (!hit && valid_mark[base + w] && tag_mem[base + w] == tag[TAG_W-1:0]) begin
                    hit = 1'b1;
                    way = w;
                end
            if (!hit)
                for (int w = 0; w < int'(nways); w++)
                    if (!empty && !valid_mark[base + w]) begin
                        empty = 1'b1;
                        way   = w;
                    end
            // Full set: evict the oldest stamp, ties go to the highest way
            if (!hit && !empty) begin
                victim = int'(nways) - 1;
                for (int w = int'(nways) - 1; w >= 0; w--)
                    if (stamp_mem[base + w] < stamp_mem[base + victim])
                        victim = w;
                way = victim;
            end
            e = int'(base) + way;
            valid_mark[e] = 1'b1;
            tag_mem[e]    = tag[TAG_W-1:0];
            stamp_mem[e]  = access_count;
            if (hit)
                hit_count = hit_count + 1'b1;
            access_count = access_count + 1'b1;

            want.hit           = hit;
            want.block_number  = blk[BLK_W-1:0];
            want.set_index     = set_no[SET_OUT_W-1:0];
            want.line_tag      = tag[TAG_W-1:0];
            want.way_used      = way[WAY_OUT_W-1:0];
            want.access_number = access_count;
            want.hit_total     = hit_count;
            owed_lookups.push_back(want);
        endfunction

        // Mostly addresses that crowd a few sets with a few more tags than ways
        function logic [ADDR_W-1:0] hot_address();
            longint unsigned bpb, sc, blk, a;
            longint unsigned set_no, tag;
            if (!geometry(kbytes, bwords, nways, bpb, sc) || $urandom_range(0, 4) == 0)
                return $urandom;
            if ($urandom_range(0, 3) != 0)
                set_no = $urandom_range(0, 3) % sc;
            else
                set_no = $urandom % sc;
            tag = $urandom_range(0, int'(nways) + 2);
            blk = tag * sc + set_no;
            a   = blk * bpb + $urandom_range(0, int'(bpb) - 1);
            return a[ADDR_W-1:0];
        endfunction

        function int pending();
            return owed_lookups.size();
        endfunction

        task report(input string msg);
            if (mismatches < 100)
                $display("%0t: error: %s", $time, msg);
            mismatches++;
        endtask

        task compare(input string name, input logic [31:0] got, input logic [31:0] want,
                     input logic [31:0] acc);
            if (got !== want)
                report($sformatf("access %0d: %s is %0h, expected %0h", acc, name, got, want));
        endtask

        task check_result(input lookup_t got);
            lookup_t want;
            if (owed_lookups.size() == 0) begin
                report($sformatf("result with no request waiting, access number %0d",
                                 got.access_number));
                return;
            end
            want = owed_lookups.pop_front();
            compare("hit",           got.hit,           want.hit,           want.access_number);
            compare("block_number",  got.block_number,  want.block_number,  want.access_number);
            compare("set_index",     got.set_index,     want.set_index,     want.access_number);
            compare("line_tag",      got.line_tag,      want.line_tag,      want.access_number);
            compare("way_used",      got.way_used,      want.way_used,      want.access_number);
            compare("access_number", got.access_number, want.access_number, want.access_number);
            compare("hit_total",     got.hit_total,     want.hit_total,     want.access_number);
            compare("config_error",  got.config_error,  want.config_error,  want.access_number);
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [ADDR_W-1:0]     s_address;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_hit;
    logic [BLK_W-1:0]      m_block_number;
    logic [SET_OUT_W-1:0]  m_set_index;
    logic [TAG_W-1:0]      m_line_tag;
    logic [WAY_OUT_W-1:0]  m_way_used;
    logic [CNT_W-1:0]      m_access_number;
    logic [CNT_W-1:0]      m_hit_total;
    logic                  m_config_error;

    cache_scoreboard sb;
    int              burst_left;
    int              ready_run;
    int              ready_mode;

    set_assoc_cache_lru_lookup uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_address       (s_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_block_number  (m_block_number),
        .m_set_index     (m_set_index),
        .m_line_tag      (m_line_tag),
        .m_way_used      (m_way_used),
        .m_access_number (m_access_number),
        .m_hit_total     (m_hit_total),
        .m_config_error  (m_config_error)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Drive every input to a known value before the first edge
    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_address = '0;
        m_ready   = 1'b0;
    end

    // Result side back-pressure: runs of always-ready, short and long stalls,
    // and cycle-by-cycle coin flips. Changes land on the falling edge only.
    initial begin
        ready_run  = 0;
        ready_mode = 0;
    end

    always @(negedge aclk) begin
        if (ready_run == 0) begin
            ready_mode = $urandom_range(0, 9);
            case (ready_mode)
                0, 1, 2, 3: ready_run = $urandom_range(1, 80);
                4, 5, 6:    ready_run = $urandom_range(1, 8);
                7, 8:       ready_run = $urandom_range(1, 30);
                default:    ready_run = $urandom_range(20, 60);
            endcase
        end
        case (ready_mode)
            0, 1, 2, 3: m_ready = 1'b1;
            7, 8:       m_ready = 1'($urandom_range(0, 1));
            default:    m_ready = 1'b0;
        endcase
        ready_run--;
    end

    // Collect a result at every rising edge where valid and ready meet
    always @(posedge aclk) begin : collect
        lookup_t got;
        if (aresetn && m_valid && m_ready) begin
            got.hit           = m_hit;
            got.block_number  = m_block_number;
            got.set_index     = m_set_index;
            got.line_tag      = m_line_tag;
            got.way_used      = m_way_used;
            got.access_number = m_access_number;
            got.hit_total     = m_hit_total;
            got.config_error  = m_config_error;
            sb.check_result(got);
        end
    end

    // Hold until every owed lookup has come back; returns on a falling edge
    task automatic wait_idle();
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    // Offer one register write and hold it until the block takes it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Rewrite all three geometry registers once the block has drained.
    // Bits above the block-words and ways widths carry noise; the block must drop them.
    task automatic set_geometry(input logic [CFG_KB_W-1:0] kb,
                                input logic [CFG_BW_W-1:0] bw,
                                input logic [CFG_WAYS_W-1:0] w);
        logic [CFG_DATA_W-1:0] d;
        wait_idle();
        write_reg(CFG_CACHE_KBYTES, kb);
        d = CFG_DATA_W'($urandom);
        d[CFG_BW_W-1:0] = bw;
        write_reg(CFG_BLOCK_WORDS, d);
        d = CFG_DATA_W'($urandom);
        d[CFG_WAYS_W-1:0] = w;
        write_reg(CFG_WAYS, d);
    endtask

    // Offer one address and hold it until accepted. Requests go out in
    // bursts; at the end of a burst drop valid for a random gap, sometimes
    // long enough for the block to go fully idle.
    task automatic send_request(input logic [ADDR_W-1:0] addr);
        s_valid   = 1'b1;
        s_address = addr;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(addr);
        @(negedge aclk);
        s_valid = 1'b0;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            s_address = $urandom;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            else
                repeat ($urandom_range(20, 150)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    initial begin : stimulus
        logic [CFG_KB_W-1:0]   kb;
        logic [CFG_BW_W-1:0]   bw;
        logic [CFG_WAYS_W-1:0] w;
        longint unsigned       bpb, sc;
        bit                    usable;
        int                    fixed_kb [4] = '{4, 1024, 3, 1};
        int                    fixed_bw [4] = '{1, 256, 7, 256};
        int                    fixed_w  [4] = '{4, 16, 5, 1};

        sb         = new();
        burst_left = $urandom_range(1, 12);

        // Hold reset, then release it on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset geometry: 4 KB, one-word blocks, direct mapped
        send_request(32'h0000_0000);
        send_request(32'hFFFF_FFFF);
        send_request(32'h0000_0000);
        send_request(32'h0000_1000);    // same set, new tag: replace
        send_request(32'h0000_0000);

        // A write to the unmapped index leaves the geometry alone
        wait_idle();
        write_reg(CFG_UNUSED, 11'h7FF);
        send_request(32'h0000_0000);

        // Unusable geometries: each register zero, too many ways,
        // no whole set, and more lines than the store holds
        set_geometry(0, 1, 1);
        send_request(32'h0000_0040);
        set_geometry(4, 0, 1);
        send_request(32'h0000_0040);
        set_geometry(4, 1, 0);
        send_request(32'h0000_0040);
        set_geometry(4, 1, 17);
        send_request(32'h0000_0040);
        set_geometry(4, 1, 31);
        send_request(32'h0000_0040);
        set_geometry(1, 256, 2);
        send_request(32'h0000_0040);
        set_geometry(1024, 1, 1);
        send_request(32'h0000_0040);
        set_geometry(2047, 511, 1);
        send_request(32'hFFFF_FFFF);

        // Smallest cache: a single line
        set_geometry(1, 256, 1);
        send_request(32'hFFFF_FFFF);
        send_request(32'h0000_03FF);
        send_request(32'h0000_0000);

        // Blocks of 256 words, widest sets; stale lines are read under new geometry
        set_geometry(1024, 256, 16);
        send_request(32'h0000_0000);
        send_request(32'hFFFF_FFFF);
        send_request(32'h0000_0400);
        set_geometry(4, 1, 16);
        send_request(32'h0000_0000);
        send_request(32'h0000_0100);
        send_request(32'h0000_0000);

        // Random phases: a few fixed geometries, then random ones that are
        // mostly usable, with the odd unusable one kept short
        for (int p = 0; p < 12; p++) begin
            if (p < 4) begin
                kb = CFG_KB_W'(fixed_kb[p]);
                bw = CFG_BW_W'(fixed_bw[p]);
                w  = CFG_WAYS_W'(fixed_w[p]);
            end else begin
                do begin
                    w = CFG_WAYS_W'($urandom_range(1, 16));
                    if ($urandom_range(0, 1) != 0)
                        bw = CFG_BW_W'(1 << $urandom_range(0, 8));
                    else
                        bw = CFG_BW_W'($urandom_range(1, 256));
                    kb = CFG_KB_W'($urandom_range(1, (4 * int'(bw) + 3 > 2047) ?
                                                     2047 : 4 * int'(bw) + 3));
                    usable = cache_scoreboard::geometry(kb, bw, w, bpb, sc);
                end while (!usable && $urandom_range(0, 7) != 0);
            end
            set_geometry(kb, bw, w);
            usable = cache_scoreboard::geometry(kb, bw, w, bpb, sc);
            repeat (usable ? 46 : 4)
                send_request(sb.hot_address());
        end

        // Drain, then give the block time to show any stray result
        wait_idle();
        repeat (200) @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/salru_pkg.sv
rtl/core/salru_div.sv
rtl/core/salru_store.sv
rtl/core/set_assoc_cache_lru_lookup.sv
rtl/core/salru_chk.sv
bench/tb_top.sv
